FILE: hw/rtl/bwmr_pkg.sv
// ----------------------------------------------------------------------------
// bwmr_pkg
// Shared types and constants of the bilinear weight-map remap block.
// ----------------------------------------------------------------------------
package bwmr_pkg;

  localparam int CHAN_W    = 8;
  localparam int PIXEL_W   = 3 * CHAN_W;
  localparam int INDEX_W   = 16;
  localparam int WEIGHT_W  = 8;
  localparam int STRIDE_W  = 13;
  localparam int FRAC_BITS = 7;

  // Widest raw address: index plus largest stride plus one.
  localparam int SPAN_W = 17;

  // Four products of 8 by 8 bits never exceed this width.
  localparam int ACC_W = 18;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd256;
  localparam logic [CHAN_W-1:0]   CHAN_MAX     = 8'hFF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_REMAP = 1'b1
  } op_t;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [ACC_W-1:0]    acc_t;

endpackage

FILE: hw/rtl/bwmr_item_if.sv
// ----------------------------------------------------------------------------
// bwmr_item_if
// Input channel: one pixel write or one map entry per transfer.
// ----------------------------------------------------------------------------
interface bwmr_item_if;
  logic                                valid;
  logic                                ready;
  bwmr_pkg::op_t                       operation;
  logic [bwmr_pkg::INDEX_W-1:0]        frame_index;
  logic                                pixel_present;
  bwmr_pkg::weight_t                   weight_nw;
  bwmr_pkg::weight_t                   weight_ne;
  bwmr_pkg::weight_t                   weight_sw;
  bwmr_pkg::weight_t                   weight_se;
  bwmr_pkg::chan_t                     red_in;
  bwmr_pkg::chan_t                     green_in;
  bwmr_pkg::chan_t                     blue_in;

  modport source (
    output valid, operation, frame_index, pixel_present,
    output weight_nw, weight_ne, weight_sw, weight_se,
    output red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, operation, frame_index, pixel_present,
    input  weight_nw, weight_ne, weight_sw, weight_se,
    input  red_in, green_in, blue_in,
    output ready
  );
endinterface

FILE: hw/rtl/bwmr_result_if.sv
// ----------------------------------------------------------------------------
// bwmr_result_if
// Output channel: one interpolated RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface bwmr_result_if;
  logic            valid;
  logic            ready;
  bwmr_pkg::chan_t red_out;
  bwmr_pkg::chan_t green_out;
  bwmr_pkg::chan_t blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

FILE: hw/rtl/bwmr_stride_if.sv
// ----------------------------------------------------------------------------
// bwmr_stride_if
// Configuration write channel for the row stride register.
// ----------------------------------------------------------------------------
interface bwmr_stride_if;
  logic                          valid;
  logic                          ready;
  logic [bwmr_pkg::STRIDE_W-1:0] row_stride;

  modport source (
    output valid, row_stride,
    input  ready
  );

  modport sink (
    input  valid, row_stride,
    output ready
  );
endinterface

FILE: hw/rtl/bilinear_weight_map_remap.sv
// ----------------------------------------------------------------------------
// bilinear_weight_map_remap
// Bilinear remap of an RGB source frame held in a single-port frame memory.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                      Transfers
//   item      in    operation, index, present, 4 weights, RGB    one item
//   result    out   red_out, green_out, blue_out                 one pixel
//   stride    in    row_stride                                   one write
//
// A remap with a present entry goes through the transfer cycle, four frame reads
// issued one per cycle on the single memory port, the address reduction and
// read latency, the DRAIN state that waits for the pipeline to empty and the
// FINISH state that loads the result. A pixel write ends after DRAIN without
// FINISH; an absent entry goes from the transfer straight to FINISH.
// Synchronous reset sets row_stride to 256 and empties the pipeline; frame
// contents are not cleared. A stalled result waits in the output register
// while the next item is taken; the next result then waits for it to leave.
// ----------------------------------------------------------------------------
module bilinear_weight_map_remap #(
  parameter int FRAME_PIXELS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  bwmr_item_if.sink            item,
  bwmr_result_if.source        result,
  bwmr_stride_if.sink          stride
);

  localparam int AddrW      = $clog2(FRAME_PIXELS);
  localparam int XW         = (AddrW > bwmr_pkg::SPAN_W) ? AddrW : bwmr_pkg::SPAN_W;
  localparam int RecipShift = XW + AddrW;
  localparam int RecipW     = XW + 1;
  localparam int ProdW      = XW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;
  // Rounded-up reciprocal; exact quotient for every raw address below 2**XW.
  localparam logic [RecipW-1:0] Recip = RecipW'(
    ((64'd1 << RecipShift) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS));

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    ISSUE  = 4'b0010,
    DRAIN  = 4'b0100,
    FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Latched item.
  bwmr_pkg::op_t                  op;
  logic [bwmr_pkg::INDEX_W-1:0]   base;
  bwmr_pkg::weight_t              weight [4];
  logic [bwmr_pkg::PIXEL_W-1:0]   wpixel;
  logic [1:0]                     tap;

  logic [bwmr_pkg::STRIDE_W-1:0]  row_stride;

  // Address pipeline.
  logic             s1_valid, s2_valid, s3_valid;
  logic [1:0]       s1_tap, s2_tap, s3_tap;
  logic [XW-1:0]    s1_x, s2_x;
  logic [ProdW-1:0] s2_prod;

  logic [XW-1:0]    raw_addr;
  logic [QuotW-1:0] quot;
  logic [XW:0]      rem;
  logic [AddrW-1:0] mem_addr;
  logic             mem_en, mem_we;
  logic [bwmr_pkg::PIXEL_W-1:0] mem_rdata;

  bwmr_pkg::acc_t acc_r, acc_g, acc_b;

  bwmr_pkg::chan_t red_q, green_q, blue_q;
  logic            out_valid;

  logic accept, out_free, last_tap, pipe_empty;

  function automatic bwmr_pkg::chan_t saturate(input bwmr_pkg::acc_t sum);
    logic [bwmr_pkg::ACC_W-bwmr_pkg::FRAC_BITS-1:0] shifted;
    shifted = sum[bwmr_pkg::ACC_W-1:bwmr_pkg::FRAC_BITS];
    if (shifted > (bwmr_pkg::ACC_W - bwmr_pkg::FRAC_BITS)'(bwmr_pkg::CHAN_MAX)) begin
      return bwmr_pkg::CHAN_MAX;
    end
    return shifted[bwmr_pkg::CHAN_W-1:0];
  endfunction

  assign item.ready   = (state == IDLE);
  assign stride.ready = 1'b1;
  assign accept       = item.valid && item.ready;
  assign out_free     = !out_valid || result.ready;
  assign last_tap     = (op == bwmr_pkg::OP_WRITE) || (tap == 2'd3);
  assign pipe_empty   = !s1_valid && !s2_valid && !s3_valid;

  assign result.valid     = out_valid;
  assign result.red_out   = red_q;
  assign result.green_out = green_q;
  assign result.blue_out  = blue_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= bwmr_pkg::STRIDE_RESET;
    end else if (stride.valid && stride.ready) begin
      row_stride <= stride.row_stride;
    end
  end

  // Raw address of the current tap: nw, ne, sw, se.
  always_comb begin
    case (tap)
      2'd0:    raw_addr = XW'(base);
      2'd1:    raw_addr = XW'(base) + XW'(1);
      2'd2:    raw_addr = XW'(base) + XW'(row_stride);
      default: raw_addr = XW'(base) + XW'(row_stride) + XW'(1);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (accept) begin
          if (item.operation == bwmr_pkg::OP_REMAP && !item.pixel_present) begin
            state_next = FINISH;
          end else begin
            state_next = ISSUE;
          end
        end
      end
      ISSUE: begin
        if (last_tap) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        if (pipe_empty) begin
          state_next = (op == bwmr_pkg::OP_REMAP) ? FINISH : IDLE;
        end
      end
      FINISH: begin
        if (out_free) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= item.operation;
      base      <= item.frame_index;
      weight[0] <= item.weight_nw;
      weight[1] <= item.weight_ne;
      weight[2] <= item.weight_sw;
      weight[3] <= item.weight_se;
      wpixel    <= {item.red_in, item.green_in, item.blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= 2'd0;
    end else if (accept) begin
      tap <= 2'd0;
    end else if (state == ISSUE && !last_tap) begin
      tap <= tap + 2'd1;
    end
  end

  // Reduction modulo the frame size: multiply by the reciprocal, then
  // subtract the quotient times the frame size in the next stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ISSUE);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && (op == bwmr_pkg::OP_REMAP);
    end
  end

  always_ff @(posedge clk) begin
    s1_x    <= raw_addr;
    s1_tap  <= tap;
    s2_x    <= s1_x;
    s2_tap  <= s1_tap;
    s2_prod <= ProdW'(s1_x) * ProdW'(Recip);
    s3_tap  <= s2_tap;
  end

  assign quot     = s2_prod[ProdW-1:RecipShift];
  assign rem      = (XW + 1)'(s2_x) - (XW + 1)'(quot) * (XW + 1)'(FRAME_PIXELS);
  assign mem_addr = rem[AddrW-1:0];
  assign mem_en   = s2_valid;
  assign mem_we   = s2_valid && (op == bwmr_pkg::OP_WRITE);

  bwmr_ram #(
    .WIDTH (bwmr_pkg::PIXEL_W),
    .DEPTH (FRAME_PIXELS)
  ) u_frame (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wpixel),
    .rdata (mem_rdata)
  );

  // One pixel per cycle: three channel multiply-accumulates.
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (s3_valid) begin
      acc_r <= acc_r + bwmr_pkg::ACC_W'(mem_rdata[23:16])
                     * bwmr_pkg::ACC_W'(weight[s3_tap]);
      acc_g <= acc_g + bwmr_pkg::ACC_W'(mem_rdata[15:8])
                     * bwmr_pkg::ACC_W'(weight[s3_tap]);
      acc_b <= acc_b + bwmr_pkg::ACC_W'(mem_rdata[7:0])
                     * bwmr_pkg::ACC_W'(weight[s3_tap]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FINISH && out_free) begin
      red_q   <= saturate(acc_r);
      green_q <= saturate(acc_g);
      blue_q  <= saturate(acc_b);
    end
  end

endmodule

FILE: hw/rtl/bwmr_ram.sv
// ----------------------------------------------------------------------------
// bwmr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bwmr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/bwmr_checker.sv
// ----------------------------------------------------------------------------
// bwmr_checker
// Port-level checks of the remap block, bound to the top level.
// ----------------------------------------------------------------------------
module bwmr_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input bwmr_pkg::op_t   item_operation,
  input logic            result_valid,
  input logic            result_ready,
  input bwmr_pkg::chan_t result_red,
  input bwmr_pkg::chan_t result_green,
  input bwmr_pkg::chan_t result_blue
);

  logic [1:0] pending;
  logic       remap_in, result_out;

  assign remap_in   = item_valid && item_ready && (item_operation == bwmr_pkg::OP_REMAP);
  assign result_out = result_valid && result_ready;

  // Remap transfers whose result has not been transferred yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, remap_in} - {1'b0, result_out};
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_red)
      && $stable(result_green) && $stable(result_blue))
    else $error("stalled result changed");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item still in work");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result without an outstanding remap item");

  a_one_waiting: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> pending <= 2'd1)
    else $error("remap item lost in work while ready");

endmodule

bind bilinear_weight_map_remap bwmr_checker u_bwmr_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .item_operation (item.operation),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_red     (result.red_out),
  .result_green   (result.green_out),
  .result_blue    (result.blue_out)
);
